### design/char_lcd_expander_sequencer_macros.svh
// Assertion helpers used by char_lcd_expander_sequencer.sv.
`ifndef CHAR_LCD_EXPANDER_SEQUENCER_MACROS_SVH
`define CHAR_LCD_EXPANDER_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define LCDX_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define LCDX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCDX_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define LCDX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

### design/lcdx_pkg.sv
package lcdx_pkg;

    localparam int NUM_ROWS_DEF    = 4;
    localparam int NUM_COLUMNS_DEF = 20;

    // Request kinds
    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_CHAR   = 3'd1;
    localparam logic [2:0] KIND_CURSOR = 3'd2;
    localparam logic [2:0] KIND_LIGHT  = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // Display commands and wake-up nibbles
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] WAKE_NIB      = 8'h30;
    localparam logic [7:0] MODE4_NIB     = 8'h20;

    localparam logic [5:0] PAUSE_WAKE0 = 6'd50;
    localparam logic [5:0] PAUSE_WAKE1 = 6'd5;
    localparam logic [5:0] PAUSE_WAKE2 = 6'd1;
    localparam logic [1:0] PAUSE_CLEAR = 2'd2;

    localparam int UADDR_W = 5;
    typedef logic [UADDR_W-1:0] uaddr_t;

    // Microprogram entry points
    localparam uaddr_t A_BYTE   = 5'd0;
    localparam uaddr_t A_CURSOR = 5'd4;
    localparam uaddr_t A_ERR    = 5'd5;
    localparam uaddr_t A_LIGHT  = 5'd6;
    localparam uaddr_t A_INIT   = 5'd7;
    localparam uaddr_t A_IDLE   = 5'd31;

    localparam uaddr_t INIT_NIB_STEPS = 5'd8;
    localparam uaddr_t INIT_STEPS     = 5'd24;

    typedef enum logic {SRC_REQ, SRC_ROM} src_t;
    typedef enum logic {HALF_HI, HALF_LO} half_t;
    typedef enum logic [1:0] {OUT_DATA, OUT_ERR, OUT_LIGHT} out_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_END, SEQ_CHK} seq_t;

    typedef struct packed {
        logic       emit;
        src_t       src;
        logic [7:0] rom_byte;
        half_t      half;
        logic       en;
        out_t       out;
        logic [5:0] pause_before;
        logic       chk_after;
        logic       last;
        seq_t       seq;
        uaddr_t     target;
    } uword_t;

    typedef struct packed {
        logic   busy;
        logic   fire;
        uword_t uw;
    } seq_ctl_t;

    typedef struct packed {
        logic slot_free;
        logic range_ok;
        logic light;
    } dp_stat_t;

    function automatic logic [7:0] line_start(input logic [1:0] r);
        logic [7:0] s;
        case (r)
            2'd0:    s = 8'h00;
            2'd1:    s = 8'h40;
            2'd2:    s = 8'h14;
            default: s = 8'h54;
        endcase
        return s;
    endfunction

    // One port byte of a nibble pair; k[1] picks the low nibble, k[0] drops enable.
    function automatic uword_t step_word(input src_t src, input logic [7:0] b,
                                         input logic [1:0] k, input logic [5:0] pb,
                                         input logic fin);
        uword_t w;
        w.emit         = 1'b1;
        w.src          = src;
        w.rom_byte     = b;
        w.half         = k[1] ? HALF_LO : HALF_HI;
        w.en           = ~k[0];
        w.out          = OUT_DATA;
        w.pause_before = pb;
        w.chk_after    = fin && (k == 2'b11);
        w.last         = fin && (k == 2'b11);
        w.seq          = (fin && (k == 2'b11)) ? SEQ_END : SEQ_NEXT;
        w.target       = A_IDLE;
        return w;
    endfunction

    function automatic uword_t ctl_word(input logic emit, input out_t out,
                                        input seq_t seq, input uaddr_t target);
        uword_t w;
        w.emit         = emit;
        w.src          = SRC_ROM;
        w.rom_byte     = 8'h00;
        w.half         = HALF_HI;
        w.en           = 1'b0;
        w.out          = out;
        w.pause_before = 6'd0;
        w.chk_after    = 1'b0;
        w.last         = emit;
        w.seq          = seq;
        w.target       = target;
        return w;
    endfunction

    // Microprogram ROM
    function automatic uword_t ucode(input uaddr_t a);
        uword_t     w;
        uaddr_t     off;
        logic [7:0] b;
        logic [5:0] pb;
        off = a - A_INIT;
        b   = 8'h00;
        pb  = 6'd0;
        if (a < A_CURSOR) begin
            w = step_word(SRC_REQ, 8'h00, a[1:0], 6'd0, 1'b1);
        end else if (a == A_CURSOR) begin
            w = ctl_word(1'b0, OUT_DATA, SEQ_CHK, A_BYTE);
        end else if (a == A_ERR) begin
            w = ctl_word(1'b1, OUT_ERR, SEQ_END, A_IDLE);
        end else if (a == A_LIGHT) begin
            w = ctl_word(1'b1, OUT_LIGHT, SEQ_END, A_IDLE);
        end else if (off < INIT_NIB_STEPS) begin
            case (off[2:1])
                2'd0:    begin b = WAKE_NIB;  pb = PAUSE_WAKE0; end
                2'd1:    begin b = WAKE_NIB;  pb = PAUSE_WAKE1; end
                2'd2:    begin b = WAKE_NIB;  pb = PAUSE_WAKE2; end
                default: begin b = MODE4_NIB; pb = 6'd0;        end
            endcase
            w = step_word(SRC_ROM, b, {1'b0, off[0]}, off[0] ? 6'd0 : pb, 1'b0);
        end else if (off < INIT_STEPS) begin
            case (off[4:2])
                3'd2:    b = CMD_FUNC_SET;
                3'd3:    b = CMD_DISP_ON;
                3'd4:    b = CMD_ENTRY;
                default: b = CMD_CLEAR;
            endcase
            w = step_word(SRC_ROM, b, off[1:0], 6'd0, off[4:2] == 3'd5);
        end else begin
            w = ctl_word(1'b0, OUT_DATA, SEQ_END, A_IDLE);
        end
        return w;
    endfunction

endpackage

### design/lcdx_sequencer.sv
module lcdx_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  lcdx_pkg::uaddr_t  entry,
    input  lcdx_pkg::dp_stat_t stat,
    output lcdx_pkg::seq_ctl_t ctl
);

    lcdx_pkg::uaddr_t pc_reg, pc_next;
    logic             busy_reg, busy_next;
    lcdx_pkg::uword_t uw;
    logic             fire;

    assign uw = lcdx_pkg::ucode(pc_reg);

    // An emitting step waits for room in the output register.
    assign fire = busy_reg && (!uw.emit || stat.slot_free);

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = entry;
        end else if (fire) begin
            unique case (uw.seq)
                lcdx_pkg::SEQ_NEXT: pc_next = pc_reg + 1'b1;
                lcdx_pkg::SEQ_CHK:  pc_next = stat.range_ok ? uw.target : pc_reg + 1'b1;
                lcdx_pkg::SEQ_END:  busy_next = 1'b0;
                default:            busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= lcdx_pkg::A_IDLE;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctl.busy = busy_reg;
    assign ctl.fire = fire;
    assign ctl.uw   = uw;

endmodule

### design/lcdx_datapath.sv
module lcdx_datapath #(
    parameter int NUM_ROWS    = lcdx_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLUMNS = lcdx_pkg::NUM_COLUMNS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [2:0]         kind,
    input  logic [7:0]         value,
    input  logic [1:0]         row,
    input  logic [5:0]         column,
    input  logic               light_on,
    input  lcdx_pkg::seq_ctl_t ctl,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [15:0]        m_tdata,
    output logic [0:0]         m_tuser,
    output logic               m_tlast,
    output lcdx_pkg::dp_stat_t stat
);

    logic [7:0]  req_byte_reg;
    logic        rs_reg;
    logic        range_ok_reg;
    logic        light_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_err_reg;
    logic        out_last_reg;

    logic        in_range;
    logic [7:0]  cursor_byte;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [3:0]  nib;
    logic [7:0]  port;
    logic [5:0]  before_ms;
    logic [1:0]  after_ms;
    logic        err;
    logic        slot_free;

    assign in_range = ({1'b0, row} < 3'(NUM_ROWS)) && (column < 6'(NUM_COLUMNS));
    assign cursor_byte = lcdx_pkg::CMD_SET_DDRAM |
                         (lcdx_pkg::line_start(row) + {2'b00, column});

    assign cur_byte = (ctl.uw.src == lcdx_pkg::SRC_REQ) ? req_byte_reg : ctl.uw.rom_byte;
    assign cur_rs   = (ctl.uw.src == lcdx_pkg::SRC_REQ) ? rs_reg : 1'b0;
    assign nib      = (ctl.uw.half == lcdx_pkg::HALF_HI) ? cur_byte[7:4] : cur_byte[3:0];

    always_comb begin
        port      = 8'h00;
        before_ms = 6'd0;
        after_ms  = 2'd0;
        err       = 1'b0;
        unique case (ctl.uw.out)
            lcdx_pkg::OUT_DATA: begin
                port      = {nib, light_reg, ctl.uw.en, 1'b0, cur_rs};
                before_ms = ctl.uw.pause_before;
                // clear and home need extra settling time after their final byte
                if (ctl.uw.chk_after && !cur_rs &&
                    (cur_byte == lcdx_pkg::CMD_CLEAR || cur_byte == lcdx_pkg::CMD_HOME)) begin
                    after_ms = lcdx_pkg::PAUSE_CLEAR;
                end
            end
            lcdx_pkg::OUT_ERR: begin
                err = 1'b1;
            end
            lcdx_pkg::OUT_LIGHT: begin
                port = {4'h0, light_reg, 3'b000};
            end
            default: begin
                port = 8'h00;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (load && kind == lcdx_pkg::KIND_LIGHT) begin
                light_reg <= light_on;
            end
            if (ctl.fire && ctl.uw.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            req_byte_reg <= (kind == lcdx_pkg::KIND_CURSOR) ? cursor_byte : value;
            rs_reg       <= (kind == lcdx_pkg::KIND_CHAR);
            range_ok_reg <= in_range;
        end
        if (ctl.fire && ctl.uw.emit) begin
            out_data_reg <= {after_ms, before_ms, port};
            out_err_reg  <= err;
            out_last_reg <= ctl.uw.last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;
    assign m_tlast    = out_last_reg;

    assign stat.slot_free = slot_free;
    assign stat.range_ok  = range_ok_reg;
    assign stat.light     = light_reg;

endmodule

### design/char_lcd_expander_sequencer.sv
// Character LCD sequencer for a 4-bit display behind an 8-bit port expander. Each request
// beat on the slave side runs a short microprogram that emits one expander byte per cycle
// on the master side while the master side does not stall: a command or character emits
// 4 bytes, a cursor set one range check step, then 4 bytes, or the check step, then a single
// error beat when out of range, a backlight set 1 byte and init 24 bytes. A new request is
// taken the cycle after the final step of the previous program issues; unused kinds are
// taken and dropped at once. The step counter walks the microcode ROM one step per clock,
// holding an emitting step while the output register is full. The backlight starts on after reset.
`include "char_lcd_expander_sequencer_macros.svh"

module char_lcd_expander_sequencer #(
    parameter int NUM_ROWS    = lcdx_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLUMNS = lcdx_pkg::NUM_COLUMNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value[7:0], row[9:8], column[15:10], light_on[16], zero
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // port_byte[7:0], pause_before_ms[13:8], pause_after_ms[15:14]
    output logic [0:0]  m_tuser,   // error[0]
    output logic        m_tlast
);

    lcdx_pkg::seq_ctl_t ctl;
    lcdx_pkg::dp_stat_t stat;
    lcdx_pkg::uaddr_t   entry;
    logic               accept;
    logic               known;

    assign s_tready = !ctl.busy;
    assign accept   = s_tvalid && s_tready;

    // Dispatch the request kind to its microprogram entry.
    always_comb begin
        known = 1'b1;
        case (s_tuser) inside
            lcdx_pkg::KIND_CMD, lcdx_pkg::KIND_CHAR: entry = lcdx_pkg::A_BYTE;
            lcdx_pkg::KIND_CURSOR:                   entry = lcdx_pkg::A_CURSOR;
            lcdx_pkg::KIND_LIGHT:                    entry = lcdx_pkg::A_LIGHT;
            lcdx_pkg::KIND_INIT:                     entry = lcdx_pkg::A_INIT;
            default: begin
                entry = lcdx_pkg::A_IDLE;
                known = 1'b0;
            end
        endcase
    end

    lcdx_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && known),
        .entry   (entry),
        .stat    (stat),
        .ctl     (ctl)
    );

    lcdx_datapath #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .kind     (s_tuser),
        .value    (s_tdata[7:0]),
        .row      (s_tdata[9:8]),
        .column   (s_tdata[15:10]),
        .light_on (s_tdata[16]),
        .ctl      (ctl),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    `LCDX_ASSERT_NOW(a_err_lone, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast && m_tdata == 16'h0000, "error beat must be a lone final beat with no data")
    `LCDX_ASSERT_NOW(a_pause_after_last, aclk, aresetn, m_tvalid && m_tdata[15:14] != 2'd0, m_tlast, "pause after only on the final beat")
    `LCDX_ASSERT_NEXT(a_light_follows, aclk, aresetn, accept && s_tuser == lcdx_pkg::KIND_LIGHT, stat.light == $past(s_tdata[16]), "backlight must follow the set request")

endmodule

### test/char_lcd_expander_sequencer_tb.sv
module char_lcd_expander_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PORT_RS = 8'h01;
    localparam logic [7:0] PORT_EN = 8'h04;
    localparam logic [7:0] PORT_BL = 8'h08;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_PER_PHASE = 24;
    localparam int DRAIN_CYCLES     = 40;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] column;
        logic       light;
    } lcd_req_t;

    typedef struct {
        logic [7:0] port;
        logic [5:0] before_ms;
        logic [1:0] after_ms;
        logic       err;
        logic       last;
    } port_beat_t;

    class lcd_scoreboard;
        logic         backlight;
        port_beat_t   expected_beats[$];
        int unsigned  failures;

        function new();
            backlight = 1'b1;
            failures  = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(logic [7:0] port, logic [5:0] pb, logic [1:0] pa, logic err);
            port_beat_t b;
            b.port      = port;
            b.before_ms = pb;
            b.after_ms  = pa;
            b.err       = err;
            b.last      = 1'b0;
            expected_beats.push_back(b);
        endfunction

        // Enable high, then enable low; RS and backlight on both.
        function void push_nibble(logic [3:0] nib, logic rs, logic [5:0] pb, logic [1:0] pa);
            logic [7:0] base;
            base = {nib, 3'b000, rs} | (backlight ? PORT_BL : 8'h00);
            push_beat(base | PORT_EN, pb, 2'd0, 1'b0);
            push_beat(base, 6'd0, pa, 1'b0);
        endfunction

        function void push_display_byte(logic [7:0] b, logic rs);
            logic [1:0] pa;
            pa = (!rs && (b == lcdx_pkg::CMD_CLEAR || b == lcdx_pkg::CMD_HOME)) ?
                 lcdx_pkg::PAUSE_CLEAR : 2'd0;
            push_nibble(b[7:4], rs, 6'd0, 2'd0);
            push_nibble(b[3:0], rs, 6'd0, pa);
        endfunction

        function void note_request(lcd_req_t r);
            int         n0;
            logic [7:0] start;
            n0 = expected_beats.size();
            case (r.kind)
                lcdx_pkg::KIND_CMD:  push_display_byte(r.value, 1'b0);
                lcdx_pkg::KIND_CHAR: push_display_byte(r.value, 1'b1);
                lcdx_pkg::KIND_CURSOR: begin
                    if (r.row >= lcdx_pkg::NUM_ROWS_DEF ||
                        r.column >= lcdx_pkg::NUM_COLUMNS_DEF) begin
                        push_beat(8'h00, 6'd0, 2'd0, 1'b1);
                    end else begin
                        case (r.row)
                            2'd0:    start = 8'h00;
                            2'd1:    start = 8'h40;
                            2'd2:    start = 8'h14;
                            default: start = 8'h54;
                        endcase
                        push_display_byte(lcdx_pkg::CMD_SET_DDRAM |
                                          (start + {2'b00, r.column}), 1'b0);
                    end
                end
                lcdx_pkg::KIND_LIGHT: begin
                    backlight = r.light;
                    push_beat(r.light ? PORT_BL : 8'h00, 6'd0, 2'd0, 1'b0);
                end
                lcdx_pkg::KIND_INIT: begin
                    push_nibble(lcdx_pkg::WAKE_NIB[7:4], 1'b0, lcdx_pkg::PAUSE_WAKE0, 2'd0);
                    push_nibble(lcdx_pkg::WAKE_NIB[7:4], 1'b0, lcdx_pkg::PAUSE_WAKE1, 2'd0);
                    push_nibble(lcdx_pkg::WAKE_NIB[7:4], 1'b0, lcdx_pkg::PAUSE_WAKE2, 2'd0);
                    push_nibble(lcdx_pkg::MODE4_NIB[7:4], 1'b0, 6'd0, 2'd0);
                    push_display_byte(lcdx_pkg::CMD_FUNC_SET, 1'b0);
                    push_display_byte(lcdx_pkg::CMD_DISP_ON, 1'b0);
                    push_display_byte(lcdx_pkg::CMD_ENTRY, 1'b0);
                    push_display_byte(lcdx_pkg::CMD_CLEAR, 1'b0);
                end
                default: ;
            endcase
            if (expected_beats.size() > n0) begin
                expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_beat(port_beat_t got);
            port_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: port_byte %h error %b last %b",
                       got.port, got.err, got.last);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.port !== want.port) begin
                $error("port_byte expected %h actual %h", want.port, got.port);
                failures++;
            end
            if (got.before_ms !== want.before_ms) begin
                $error("pause_before_ms expected %0d actual %0d", want.before_ms, got.before_ms);
                failures++;
            end
            if (got.after_ms !== want.after_ms) begin
                $error("pause_after_ms expected %0d actual %0d", want.after_ms, got.after_ms);
                failures++;
            end
            if (got.err !== want.err) begin
                $error("error expected %b actual %b", want.err, got.err);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last expected %b actual %b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    lcd_scoreboard sb;
    int unsigned   idle_pct  = 0;
    int unsigned   stall_pct = 0;

    char_lcd_expander_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Check each accepted result beat, then pick next cycle's ready.
    always @(posedge aclk) begin
        port_beat_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.port      = m_tdata[7:0];
            got.before_ms = m_tdata[13:8];
            got.after_ms  = m_tdata[15:14];
            got.err       = m_tuser[0];
            got.last      = m_tlast;
            sb.check_beat(got);
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic lcd_req_t make_req(logic [2:0] kind, logic [7:0] value,
                                          logic [1:0] row, logic [5:0] column,
                                          logic light);
        lcd_req_t r;
        r.kind   = kind;
        r.value  = value;
        r.row    = row;
        r.column = column;
        r.light  = light;
        return r;
    endfunction

    // Mostly well-formed requests; a few out-of-range cursors and spare kinds.
    function automatic lcd_req_t random_req();
        lcd_req_t    r;
        int unsigned pick;
        r.value  = 8'($urandom_range(255));
        r.row    = 2'($urandom_range(3));
        r.column = 6'($urandom_range(63));
        r.light  = 1'($urandom_range(1));
        pick     = $urandom_range(99);
        if (pick < 25) begin
            r.kind = lcdx_pkg::KIND_CMD;
            if ($urandom_range(9) == 0) begin
                r.value = $urandom_range(1) ? lcdx_pkg::CMD_CLEAR : lcdx_pkg::CMD_HOME;
            end
        end else if (pick < 50) begin
            r.kind = lcdx_pkg::KIND_CHAR;
        end else if (pick < 72) begin
            r.kind = lcdx_pkg::KIND_CURSOR;
            if ($urandom_range(3) != 0) begin
                r.column = 6'($urandom_range(lcdx_pkg::NUM_COLUMNS_DEF - 1));
            end
        end else if (pick < 84) begin
            r.kind = lcdx_pkg::KIND_LIGHT;
        end else if (pick < 93) begin
            r.kind = lcdx_pkg::KIND_INIT;
        end else begin
            r.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        end
        return r;
    endfunction

    // Call at a rising edge; returns at the edge where the beat was taken.
    task automatic send_request(lcd_req_t r);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, r.light, r.column, r.row, r.value};
        s_tuser  <= r.kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned idle_tbl[4];
        int unsigned stall_tbl[4];
        idle_tbl  = '{0, 67, 0, 22};
        stall_tbl = '{0, 0, 67, 22};
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(make_req(lcdx_pkg::KIND_CMD, 8'h00, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CMD, 8'hFF, 2'd3, 6'd63, 1'b1));
        send_request(make_req(lcdx_pkg::KIND_CMD, lcdx_pkg::CMD_CLEAR, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CMD, lcdx_pkg::CMD_HOME, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CHAR, 8'h00, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CHAR, 8'hFF, 2'd3, 6'd63, 1'b1));
        // clear and home codes as characters carry no pause
        send_request(make_req(lcdx_pkg::KIND_CHAR, lcdx_pkg::CMD_CLEAR, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CHAR, lcdx_pkg::CMD_HOME, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CURSOR, 8'h00, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CURSOR, 8'hFF, 2'd1, 6'd19, 1'b1));
        send_request(make_req(lcdx_pkg::KIND_CURSOR, 8'h00, 2'd2, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CURSOR, 8'h00, 2'd3, 6'd19, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CURSOR, 8'h00, 2'd0, 6'd20, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CURSOR, 8'hFF, 2'd3, 6'd63, 1'b1));
        send_request(make_req(lcdx_pkg::KIND_INIT, 8'h00, 2'd0, 6'd0, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_LIGHT, 8'hFF, 2'd3, 6'd63, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CHAR, 8'hA5, 2'd0, 6'd0, 1'b1));
        send_request(make_req(lcdx_pkg::KIND_INIT, 8'hFF, 2'd3, 6'd63, 1'b1));
        send_request(make_req(lcdx_pkg::KIND_LIGHT, 8'h00, 2'd0, 6'd0, 1'b1));
        send_request(make_req(lcdx_pkg::KIND_CMD, 8'h5A, 2'd0, 6'd0, 1'b0));
        // spare kinds are dropped without output
        send_request(make_req(KIND_SPARE_LO, 8'hFF, 2'd3, 6'd63, 1'b1));
        send_request(make_req(3'd6, 8'h00, 2'd0, 6'd0, 1'b0));
        send_request(make_req(KIND_SPARE_HI, 8'h81, 2'd2, 6'd5, 1'b0));
        send_request(make_req(lcdx_pkg::KIND_CHAR, 8'h3C, 2'd0, 6'd0, 1'b0));
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tbl[p];
            stall_pct = stall_tbl[p];
            repeat (RANDOM_PER_PHASE) send_request(random_req());
            drain();
        end

        if (sb.failures == 0) begin
            $display("char_lcd_expander_sequencer: match");
        end else begin
            $display("char_lcd_expander_sequencer: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("char_lcd_expander_sequencer: mismatch");
        $finish;
    end
endmodule
